[rtl/core/trapezoid_pulse_waveform_defines.svh]
// Assertion macros for the trapezoid pulse waveform block.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef TRAPEZOID_PULSE_WAVEFORM_DEFINES_SVH
`define TRAPEZOID_PULSE_WAVEFORM_DEFINES_SVH

// Implication in the same cycle, checked outside reset.
`define TPW_ASSERT_HOLD(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tpw check failed");

// Implication in the next cycle, also checked across reset.
`define TPW_ASSERT_AFTER(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("tpw check failed");

`endif

[rtl/core/tpw_pkg.sv]
// Shared constants and types for the trapezoid pulse waveform block.
// No dependencies.
package tpw_pkg;

  localparam int LEVEL_BITS_DEF = 16;
  localparam int TICK_BITS_DEF  = 24;
  localparam int TIME_BITS      = 32;
  localparam int CNT_BITS       = 16;
  localparam int CFG_IDX_BITS   = 3;
  localparam int SEG_BITS       = 3;

  // Waveform segment reported with each sample.
  typedef enum logic [SEG_BITS-1:0] {
    SEG_DELAY = 3'd0,
    SEG_RISE  = 3'd1,
    SEG_ON    = 3'd2,
    SEG_FALL  = 3'd3,
    SEG_OFF   = 3'd4,
    SEG_DONE  = 3'd5
  } seg_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_IDLE   = 3'd0,
    REG_PULSE  = 3'd1,
    REG_DELAY  = 3'd2,
    REG_RISE   = 3'd3,
    REG_ON     = 3'd4,
    REG_FALL   = 3'd5,
    REG_PERIOD = 3'd6,
    REG_COUNT  = 3'd7
  } cfg_idx_t;

endpackage

[rtl/core/tpw_if.sv]
// Valid/ready stream interfaces for the trapezoid pulse waveform block.
// Depends on tpw_pkg for the time width.
interface tpw_in_if import tpw_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [TIME_BITS-1:0] time_tick;

  modport source (output valid, output time_tick, input ready);
  modport sink (input valid, input time_tick, output ready);
endinterface

interface tpw_out_if import tpw_pkg::*; #(
  parameter int LEVEL_BITS = LEVEL_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [LEVEL_BITS-1:0] level;
  logic [SEG_BITS-1:0]   segment;

  modport source (output valid, output level, output segment, input ready);
  modport sink (input valid, input level, input segment, output ready);
endinterface

[rtl/core/trapezoid_pulse_waveform.sv]
// Trapezoid pulse waveform source: time index in, level and segment out.
// Depends on tpw_pkg, tpw_if and trapezoid_pulse_waveform_defines.svh.
//
// Usage: each request on in_ch carries a time index; one result with the
// signed level and the segment code leaves on out_ch for each request, in
// order. Registers are written through cfg_we/cfg_index/cfg_wdata while the
// block is idle. in_ch.ready stays low in the cycle of a write and while the
// write shifts through cfg_hold_r, and after reset until cfg_hold_r clears,
// while the limits that are derived from the registers settle.
// Throughput: one request per clock while out_ch takes results and no write
// holds the input. The pipeline depth is set by the 32 one-bit steps of the
// period remainder and the LEVEL_BITS+1 one-bit steps of the ramp quotient.
// Every stage has its own valid bit; a stage loads when it is empty or its
// successor loads, so bubbles close up under backpressure.
// When out_ch stalls, results hold and the pipeline fills; outside the
// settling cycles in_ch.ready drops only when every stage holds a request.
// Reset clears the config registers and valid bits, which empties the pipeline.
`include "trapezoid_pulse_waveform_defines.svh"

module trapezoid_pulse_waveform import tpw_pkg::*; #(
  parameter int LEVEL_BITS = LEVEL_BITS_DEF,
  parameter int TICK_BITS  = TICK_BITS_DEF,
  localparam int CFG_W0    = (LEVEL_BITS > TICK_BITS) ? LEVEL_BITS : TICK_BITS,
  localparam int CFG_W     = (CFG_W0 > CNT_BITS) ? CFG_W0 : CNT_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [CFG_W-1:0]        cfg_wdata,
  tpw_in_if.sink                  in_ch,
  tpw_out_if.source               out_ch
);

  localparam int QB   = LEVEL_BITS + 1;          // quotient / magnitude bits
  localparam int PW   = QB + TICK_BITS;          // ramp product width
  localparam int EW   = TICK_BITS + CNT_BITS + 1; // train end width
  localparam int CMPW = (EW > TIME_BITS) ? EW : TIME_BITS + 1;
  localparam int NS   = 37 + QB;                 // stages including output

  // Configuration registers.
  logic signed [LEVEL_BITS-1:0] idle_r, pulse_r;
  logic [TICK_BITS-1:0]         delay_r, rise_r, on_r, fall_r, period_r;
  logic [CNT_BITS-1:0]          count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_r   <= '0;
      pulse_r  <= '0;
      delay_r  <= '0;
      rise_r   <= '0;
      on_r     <= '0;
      fall_r   <= '0;
      period_r <= '0;
      count_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_IDLE:   idle_r   <= cfg_wdata[LEVEL_BITS-1:0];
        REG_PULSE:  pulse_r  <= cfg_wdata[LEVEL_BITS-1:0];
        REG_DELAY:  delay_r  <= cfg_wdata[TICK_BITS-1:0];
        REG_RISE:   rise_r   <= cfg_wdata[TICK_BITS-1:0];
        REG_ON:     on_r     <= cfg_wdata[TICK_BITS-1:0];
        REG_FALL:   fall_r   <= cfg_wdata[TICK_BITS-1:0];
        REG_PERIOD: period_r <= cfg_wdata[TICK_BITS-1:0];
        REG_COUNT:  count_r  <= cfg_wdata[CNT_BITS-1:0];
        default:    ;
      endcase
    end
  end

  // Values derived from the registers, recomputed every cycle.
  logic [EW-1:0]         span_r, end_r;
  logic [TICK_BITS:0]    e2_r;
  logic [TICK_BITS+1:0]  e3_r;
  logic [QB-1:0]         mag_r;
  logic                  neg_r;
  logic signed [QB-1:0]  diff;

  assign diff = QB'(pulse_r) - QB'(idle_r);

  always_ff @(posedge clk) begin
    span_r <= EW'(count_r) * EW'(period_r);
    end_r  <= EW'(delay_r) + span_r;
    e2_r   <= (TICK_BITS+1)'(rise_r) + (TICK_BITS+1)'(on_r);
    e3_r   <= (TICK_BITS+2)'(e2_r) + (TICK_BITS+2)'(fall_r);
    neg_r  <= diff[QB-1];
    mag_r  <= diff[QB-1] ? QB'(-diff) : QB'(diff);
  end

  // Input hold while the derived values settle after reset or a write.
  logic [1:0] cfg_hold_r;
  logic       cfg_hold;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_hold_r <= 2'b11;
    end else begin
      cfg_hold_r <= {cfg_hold_r[0], cfg_we};
    end
  end

  assign cfg_hold = cfg_we || (|cfg_hold_r);

  // Pipeline flow control: a stage loads when empty or when its successor loads.
  logic [NS-1:0] vld_r;
  logic [NS:0]   ld;

  always_comb begin
    ld[NS] = out_ch.ready;
    for (int i = NS - 1; i >= 0; i--) begin
      ld[i] = !vld_r[i] || ld[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (ld[0]) vld_r[0] <= in_ch.valid && !cfg_hold;
      for (int i = 1; i < NS; i++) begin
        if (ld[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  assign in_ch.ready = ld[0] && !cfg_hold;

  // Stage 0: input register.
  logic [TIME_BITS-1:0] t0_r;

  always_ff @(posedge clk) begin
    if (ld[0]) t0_r <= in_ch.time_tick;
  end

  // Stage 1: delay and train-end checks, start of the period remainder.
  logic [TICK_BITS-1:0] m_rem_r [0:TIME_BITS];
  logic [TIME_BITS-1:0] m_dv_r  [0:TIME_BITS];
  seg_t                 m_seg_r [0:TIME_BITS];

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      m_rem_r[0] <= '0;
      m_dv_r[0]  <= t0_r - TIME_BITS'(delay_r);
      if (t0_r <= TIME_BITS'(delay_r)) begin
        m_seg_r[0] <= SEG_DELAY;
      end else if (CMPW'(t0_r) >= CMPW'(end_r)) begin
        m_seg_r[0] <= SEG_DONE;
      end else begin
        m_seg_r[0] <= SEG_RISE;  // active; refined after the remainder
      end
    end
  end

  // Period remainder, one dividend bit per stage.
  for (genvar j = 0; j < TIME_BITS; j++) begin : g_mod
    logic [TICK_BITS:0] x;
    logic               ge;
    assign x  = {m_rem_r[j], m_dv_r[j][TIME_BITS-1]};
    assign ge = x >= {1'b0, period_r};

    always_ff @(posedge clk) begin
      if (ld[2+j]) begin
        m_rem_r[j+1] <= ge ? TICK_BITS'(x - {1'b0, period_r}) : x[TICK_BITS-1:0];
        m_dv_r[j+1]  <= {m_dv_r[j][TIME_BITS-2:0], 1'b0};
        m_seg_r[j+1] <= m_seg_r[j];
      end
    end
  end

  // Segment classification and ramp operand selection.
  logic [TICK_BITS-1:0] rel;
  seg_t                 s2_seg_r;
  logic [TICK_BITS-1:0] s2_num_r, s2_den_r;

  assign rel = m_rem_r[TIME_BITS];

  always_ff @(posedge clk) begin
    if (ld[34]) begin
      s2_num_r <= rel;
      s2_den_r <= rise_r;
      if (m_seg_r[TIME_BITS] != SEG_RISE) begin
        s2_seg_r <= m_seg_r[TIME_BITS];
      end else if (rel < rise_r) begin
        s2_seg_r <= SEG_RISE;
      end else if ((TICK_BITS+1)'(rel) < e2_r) begin
        s2_seg_r <= SEG_ON;
      end else if ((TICK_BITS+2)'(rel) < e3_r) begin
        s2_seg_r <= SEG_FALL;
        s2_num_r <= TICK_BITS'((TICK_BITS+1)'(rel) - e2_r);
        s2_den_r <= fall_r;
      end else begin
        s2_seg_r <= SEG_OFF;
      end
    end
  end

  // Ramp product, then the quotient one bit per stage.
  logic [TICK_BITS-1:0] q_rem_r [0:QB];
  logic [QB-1:0]        q_low_r [0:QB];
  logic [TICK_BITS-1:0] q_den_r [0:QB];
  seg_t                 q_seg_r [0:QB];
  logic [PW-1:0]        prod;

  assign prod = PW'(mag_r) * PW'(s2_num_r);

  always_ff @(posedge clk) begin
    if (ld[35]) begin
      q_rem_r[0] <= prod[PW-1:QB];
      q_low_r[0] <= prod[QB-1:0];
      q_den_r[0] <= s2_den_r;
      q_seg_r[0] <= s2_seg_r;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_div
    logic [TICK_BITS:0] x;
    logic               ge;
    assign x  = {q_rem_r[k], q_low_r[k][QB-1]};
    assign ge = x >= {1'b0, q_den_r[k]};

    always_ff @(posedge clk) begin
      if (ld[36+k]) begin
        q_rem_r[k+1] <= ge ? TICK_BITS'(x - {1'b0, q_den_r[k]}) : x[TICK_BITS-1:0];
        q_low_r[k+1] <= {q_low_r[k][QB-2:0], ge};
        q_den_r[k+1] <= q_den_r[k];
        q_seg_r[k+1] <= q_seg_r[k];
      end
    end
  end

  // Output stage: apply the signed ramp step to the proper base level.
  logic signed [QB:0]           step;
  logic signed [QB:0]           lvl;
  logic signed [LEVEL_BITS-1:0] lvl_r;
  seg_t                         seg_out_r;

  assign step = neg_r ? -$signed({1'b0, q_low_r[QB]}) : $signed({1'b0, q_low_r[QB]});

  always_comb begin
    unique case (q_seg_r[QB])
      SEG_RISE: lvl = (QB+1)'(idle_r) + step;
      SEG_FALL: lvl = (QB+1)'(pulse_r) - step;
      SEG_ON:   lvl = (QB+1)'(pulse_r);
      default:  lvl = (QB+1)'(idle_r);
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld[NS-1]) begin
      lvl_r     <= lvl[LEVEL_BITS-1:0];
      seg_out_r <= q_seg_r[QB];
    end
  end

  assign out_ch.valid   = vld_r[NS-1];
  assign out_ch.level   = lvl_r;
  assign out_ch.segment = seg_out_r;

  // Checks.
  `TPW_ASSERT_AFTER(a_reset_empties, !rst_n, vld_r == '0)
  `TPW_ASSERT_HOLD(a_stall_only_full, !in_ch.ready, cfg_hold || ((&vld_r) && !out_ch.ready))

endmodule

[test/tpw_tb_if_note.sv]
// Holds no logic of its own: the testbench reuses the stream interfaces from the RTL
// (tpw_in_if and tpw_out_if). Kept so that the test folder lists its files in build order.
// Depends on tpw_pkg.
package tpw_tb_consts;
  import tpw_pkg::*;
  localparam int LVL_W = LEVEL_BITS_DEF;
  localparam int TCK_W = TICK_BITS_DEF;
endpackage

[test/trapezoid_pulse_waveform_tb.sv]
// Testbench for the trapezoid pulse waveform: drives time indexes under directed and
// random register settings and checks each level and segment with a local predictor.
// Depends on tpw_pkg, tpw_if, tpw_tb_consts and the block itself.
module trapezoid_pulse_waveform_tb;
  import tpw_pkg::*;
  import tpw_tb_consts::*;

  localparam int LATENCY = LVL_W + 38;
  localparam int WATCHDOG = 20000;

  // One expected sample.
  typedef struct packed {
    logic signed [LVL_W-1:0] level;
    seg_t                    segment;
  } sample_t;

  // Predictor and store of expected samples.
  class pulse_scoreboard;
    logic signed [LVL_W-1:0] idle_lvl, pulse_lvl;
    logic [TCK_W-1:0] delay_t, rise_t, on_t, fall_t, period_t;
    logic [15:0] n_cycles;
    sample_t pending[$];
    int errors;

    function void write_reg(cfg_idx_t idx, logic [TCK_W-1:0] v);
      case (idx)
        REG_IDLE:   idle_lvl = v[LVL_W-1:0];
        REG_PULSE:  pulse_lvl = v[LVL_W-1:0];
        REG_DELAY:  delay_t = v;
        REG_RISE:   rise_t = v;
        REG_ON:     on_t = v;
        REG_FALL:   fall_t = v;
        REG_PERIOD: period_t = v;
        REG_COUNT:  n_cycles = v[15:0];
        default: ;
      endcase
    endfunction

    // Scale a signed difference by num/den, truncating toward zero.
    function longint ramp_step(longint d, longint num, longint den);
      longint mag;
      mag = (d < 0) ? -d : d;
      mag = (mag * num) / den;
      return (d < 0) ? -mag : mag;
    endfunction

    function void note_request(logic [31:0] t);
      longint idle, pulse, diff, lvl, rel, e1, e2, e3;
      sample_t s;
      idle = idle_lvl;
      pulse = pulse_lvl;
      diff = pulse - idle;
      lvl = idle;
      if (longint'(t) <= longint'(delay_t)) s.segment = SEG_DELAY;
      else if (period_t != 0 &&
               longint'(t) < longint'(delay_t) + longint'(n_cycles) * longint'(period_t)) begin
        rel = (longint'(t) - longint'(delay_t)) % longint'(period_t);
        e1 = rise_t;
        e2 = e1 + on_t;
        e3 = e2 + fall_t;
        if (rel < e1) begin
          s.segment = SEG_RISE;
          lvl = idle + ramp_step(diff, rel, e1);
        end else if (rel < e2) begin
          s.segment = SEG_ON;
          lvl = pulse;
        end else if (rel < e3) begin
          s.segment = SEG_FALL;
          lvl = pulse - ramp_step(diff, rel - e2, fall_t);
        end else s.segment = SEG_OFF;
      end else s.segment = SEG_DONE;
      s.level = lvl[LVL_W-1:0];
      pending.push_back(s);
    endfunction

    function void check_result(logic [LVL_W-1:0] lvl, logic [2:0] seg);
      sample_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result level=%0d seg=%0d", $signed(lvl), seg);
        return;
      end
      e = pending.pop_front();
      if (e.level !== lvl || e.segment !== seg) begin
        errors++;
        if (errors <= 10)
          $display("bad result: expected level=%0d seg=%0d, got level=%0d seg=%0d",
                   e.level, e.segment, $signed(lvl), seg);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [TCK_W-1:0] cfg_wdata = '0;
  tpw_in_if in_ch();
  tpw_out_if #(.LEVEL_BITS(LVL_W)) out_ch();

  pulse_scoreboard board = new();
  int idle_cycles = 0;
  int hold_off = 0;
  bit sending_done = 1'b0;

  trapezoid_pulse_waveform i_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.time_tick = '0;
    out_ch.ready = 1'b0;
  end

  // Check results and note accepted requests at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) board.note_request(in_ch.time_tick);
      if (out_ch.valid && out_ch.ready) board.check_result(out_ch.level, out_ch.segment);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("trapezoid_pulse_waveform: mismatch");
        $finish;
      end
    end
  end

  // Receiver stall pattern, with one long hold-off on request.
  always @(negedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else if (hold_off > 0) begin
      out_ch.ready <= 1'b0;
      hold_off <= hold_off - 1;
    end else if (sending_done) out_ch.ready <= 1'b1;
    else out_ch.ready <= ($urandom_range(0, 99) < 70);
  end

  task automatic write_reg(cfg_idx_t idx, logic [TCK_W-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    board.write_reg(idx, v);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every expected sample has come, then let the pipeline settle.
  task automatic drain();
    while (board.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  // Offer one request and hold it until it is taken.
  task automatic send_time(logic [31:0] t);
    in_ch.valid <= 1'b1;
    in_ch.time_tick <= t;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_gap();
    in_ch.valid <= 1'b0;
    repeat ($urandom_range(1, 6)) @(negedge clk);
  endtask

  // Pick a time near the segment edges of the current setting, inside a period, or at random.
  function automatic logic [31:0] pick_time();
    int unsigned sel;
    longint base;
    sel = $urandom_range(0, 9);
    base = longint'(board.delay_t) +
           longint'(board.period_t) * $urandom_range(0, 3) + $urandom_range(0, 2);
    case (sel)
      0: return $urandom();
      1: return 32'(board.delay_t + $urandom_range(0, 1));
      2: return 32'(base + board.rise_t - $urandom_range(0, 1));
      3: return 32'(base + board.rise_t + board.on_t - $urandom_range(0, 1));
      4: return 32'(base + board.rise_t + board.on_t + board.fall_t - $urandom_range(0, 1));
      5: return 32'(longint'(board.delay_t) + longint'(board.n_cycles) * board.period_t
                    - $urandom_range(0, 1));
      default: return 32'(base + $urandom_range(0, board.period_t + 2));
    endcase
  endfunction

  task automatic random_settings(bit wide);
    write_reg(REG_IDLE, TCK_W'($urandom()));
    write_reg(REG_PULSE, TCK_W'($urandom()));
    write_reg(REG_DELAY, TCK_W'(wide ? $urandom() : $urandom_range(0, 50)));
    write_reg(REG_RISE, TCK_W'(wide ? $urandom() : $urandom_range(0, 20)));
    write_reg(REG_ON, TCK_W'(wide ? $urandom() : $urandom_range(0, 20)));
    write_reg(REG_FALL, TCK_W'(wide ? $urandom() : $urandom_range(0, 20)));
    write_reg(REG_PERIOD, TCK_W'(wide ? $urandom() : $urandom_range(0, 70)));
    write_reg(REG_COUNT, TCK_W'(wide ? $urandom() : $urandom_range(0, 6)));
  endtask

  initial begin
    int n;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: extremes of levels and times, zero period, overrunning segments.
    write_reg(REG_IDLE, 24'h008000);
    write_reg(REG_PULSE, 24'h007FFF);
    write_reg(REG_DELAY, 24'd10);
    write_reg(REG_RISE, 24'd7);
    write_reg(REG_ON, 24'd3);
    write_reg(REG_FALL, 24'd5);
    write_reg(REG_PERIOD, 24'd20);
    write_reg(REG_COUNT, 24'd2);
    for (int k = 0; k <= 52; k += 4) send_time(k);
    send_time(32'hFFFF_FFFF);
    send_gap();
    drain();
    write_reg(REG_PERIOD, 24'd0);
    send_time(5);
    send_time(12);
    send_gap();
    drain();
    write_reg(REG_PERIOD, 24'd9);
    write_reg(REG_IDLE, 24'h007FFF);
    write_reg(REG_PULSE, 24'h008000);
    for (int k = 10; k < 30; k += 3) send_time(k);
    send_gap();
    drain();
    write_reg(REG_DELAY, 24'hFFFFFF);
    write_reg(REG_PERIOD, 24'hFFFFFF);
    write_reg(REG_COUNT, 24'h00FFFF);
    write_reg(REG_RISE, 24'hFFFFFF);
    send_time(32'h0100_0000);
    send_time(32'hFFFF_FFFF);
    send_gap();
    drain();

    // Random part in phases; one phase fills the block under a long hold-off.
    n = 0;
    for (int phase = 0; phase < 12; phase++) begin
      random_settings(phase % 4 == 3);
      if (phase == 5) hold_off = 3 * LATENCY;
      for (int k = 0; k < 155; k++) begin
        send_time(pick_time());
        n++;
        if ($urandom_range(0, 9) == 0) send_gap();
      end
      in_ch.valid <= 1'b0;
      drain();
    end

    sending_done = 1'b1;
    drain();
    if (board.errors == 0) $display("trapezoid_pulse_waveform: match");
    else $display("trapezoid_pulse_waveform: mismatch");
    $finish;
  end
endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/tpw_pkg.sv
rtl/core/tpw_if.sv
rtl/core/trapezoid_pulse_waveform.sv
test/tpw_tb_if_note.sv
test/trapezoid_pulse_waveform_tb.sv
